### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the speed profile RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is asserted
`define PK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds through reset
`define PK_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PK_ASSERT(lbl, clk, rst_n, prop, msg)
`define PK_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### design/pkspd_pkg.sv
// ----------------------------------------------------------------------------
// pkspd_pkg
// Types and constants of the piecewise kinematic speed profile
// ----------------------------------------------------------------------------
`default_nettype none

package pkspd_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT1,
    ST_TOTAL,
    ST_DECIDE,
    ST_MULV,
    ST_MULA,
    ST_RAD,
    ST_ROOT2,
    ST_FINISH
  } pkspd_state_e;

  // speed segment chosen by distance
  typedef enum logic [2:0] {
    SEG_HOLD,
    SEG_ONE,
    SEG_TWO,
    SEG_THREE,
    SEG_PAST
  } pkspd_seg_e;

  // configuration register indexes
  localparam logic [2:0] CFG_ACCEL_ONE   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_TWO   = 3'd1;
  localparam logic [2:0] CFG_ACCEL_THREE = 3'd2;
  localparam logic [2:0] CFG_END_ONE     = 3'd3;
  localparam logic [2:0] CFG_END_TWO     = 3'd4;
  localparam logic [2:0] CFG_END_THREE   = 3'd5;
  localparam logic [2:0] CFG_SPEED_ONE   = 3'd6;
  localparam logic [2:0] CFG_SPEED_TWO   = 3'd7;

  // distance tolerance around segment boundaries, 1/256 m
  localparam logic signed [33:0] EPS_DIST = 34'sd1;
  // saturation limit of the accumulated distance
  localparam logic signed [33:0] DIST_MAX = 34'sd2147483647;
  // result bits produced by the root unit, one per cycle
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned ROOT_CW    = $clog2(ROOT_STEPS);

  // shared multiplier request
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } pkspd_mul_req_t;

  // root unit request and status
  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } pkspd_root_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } pkspd_root_sts_t;

endpackage

`default_nettype wire

### design/piecewise_kinematic_speed_profile.sv
// A point runs in order through the sequencer states; a first point skips the step root,
// and a point that needs no speed root goes from the segment choice or radicand to finish.
// One input transaction is taken at a time: the next is accepted only once the sequencer
// is back in idle; the shared bit-serial root unit, run up to twice per point, is the
// longest part of a point. Result waits in an output reg; a stalled result holds finish.
// Reset (rst_ni, asynchronous, active low) clears configuration, state, previous point and speed.
// ----------------------------------------------------------------------------
// piecewise_kinematic_speed_profile
// Target speed and accumulated distance per path point, sequenced over a
// shared multiplier and a shared square root unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module piecewise_kinematic_speed_profile
  import pkspd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point_x[31:0], point_y[63:32], start_speed[79:64], start_offset[111:80],
  // lower_bound[127:112], upper_bound[143:128]
  input  wire logic [143:0] s_axis_tdata,
  // first_point[0]
  input  wire logic         s_axis_tuser,
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // target_speed[15:0], planned_distance[47:16]
  output logic [47:0]       m_axis_tdata
);

  // configuration registers
  logic signed [15:0] accel_one_q, accel_two_q, accel_three_q;
  logic signed [31:0] end_one_q, end_two_q, end_three_q;
  logic [15:0]        speed_one_q, speed_two_q;

  // captured input transaction
  logic signed [31:0] px_q, py_q, off_q;
  logic               first_q;
  logic [15:0]        vs_q, lo_q, hi_q;

  // trajectory state
  logic signed [31:0] prev_x_q, prev_y_q, dist_q;
  logic [15:0]        prev_speed_q;

  // work registers
  pkspd_state_e       state_q, state_d;
  pkspd_seg_e         seg_q;
  logic [63:0]        sx_q;
  logic [32:0]        step_q;
  logic signed [31:0] total_q;
  logic [31:0]        span_q;
  logic [15:0]        amag_q;
  logic               aneg_q;
  logic [31:0]        vsq_q;
  logic [24:0]        root_q;
  logic               rneg_q;

  // output register
  logic               m_valid_q;
  logic [15:0]        out_speed_q;
  logic signed [31:0] out_dist_q;

  pkspd_mul_req_t     mul_req;
  logic [63:0]        mul_p;
  pkspd_root_req_t    root_req;
  pkspd_root_sts_t    root_sts;

  // shared units
  pkspd_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_p)
  );

  pkspd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .sts_o  (root_sts)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_one_q   <= '0;
      accel_two_q   <= '0;
      accel_three_q <= '0;
      end_one_q     <= '0;
      end_two_q     <= '0;
      end_three_q   <= '0;
      speed_one_q   <= '0;
      speed_two_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACCEL_ONE:   accel_one_q   <= cfg_data_i[15:0];
        CFG_ACCEL_TWO:   accel_two_q   <= cfg_data_i[15:0];
        CFG_ACCEL_THREE: accel_three_q <= cfg_data_i[15:0];
        CFG_END_ONE:     end_one_q     <= cfg_data_i;
        CFG_END_TWO:     end_two_q     <= cfg_data_i;
        CFG_END_THREE:   end_three_q   <= cfg_data_i;
        CFG_SPEED_ONE:   speed_one_q   <= cfg_data_i[15:0];
        CFG_SPEED_TWO:   speed_two_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // coordinate differences and their magnitudes
  logic signed [32:0] dx, dy;
  logic [32:0]        dx_abs, dy_abs;
  logic [31:0]        ax, ay;
  always_comb begin
    dx     = {px_q[31], px_q} - {prev_x_q[31], prev_x_q};
    dy     = {py_q[31], py_q} - {prev_y_q[31], prev_y_q};
    dx_abs = dx[32] ? (-dx) : dx;
    dy_abs = dy[32] ? (-dy) : dy;
    ax     = dx_abs[31:0];
    ay     = dy_abs[31:0];
  end

  // sum of squares, carry out means the step saturates
  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, sx_q} + {1'b0, mul_p};

  // accumulated distance with saturation
  logic signed [33:0] acc_sum;
  logic signed [31:0] total_new;
  always_comb begin
    acc_sum = {{2{dist_q[31]}}, dist_q} + {1'b0, step_q};
    if (first_q) begin
      total_new = off_q[31] ? off_q : '0;
    end else if (acc_sum > DIST_MAX) begin
      total_new = DIST_MAX[31:0];
    end else begin
      total_new = acc_sum[31:0];
    end
  end

  // segment selection by distance
  logic signed [33:0] tot34, e1, e2, e3;
  pkspd_seg_e         seg_new;
  logic signed [33:0] span_new;
  logic signed [15:0] accel_sel;
  logic [16:0]        accel_abs;
  always_comb begin
    tot34 = {{2{total_q[31]}}, total_q};
    e1    = {{2{end_one_q[31]}}, end_one_q};
    e2    = {{2{end_two_q[31]}}, end_two_q};
    e3    = {{2{end_three_q[31]}}, end_three_q};
    if (tot34 <= EPS_DIST) begin
      seg_new = SEG_HOLD;
    end else if (tot34 <= e1 + EPS_DIST) begin
      seg_new = SEG_ONE;
    end else if (tot34 > e1 && tot34 <= e2 + EPS_DIST) begin
      seg_new = SEG_TWO;
    end else if (tot34 > e2 && tot34 <= e3 + EPS_DIST) begin
      seg_new = SEG_THREE;
    end else begin
      seg_new = SEG_PAST;
    end
    case (seg_new)
      SEG_TWO: begin
        span_new  = tot34 - e1;
        accel_sel = accel_two_q;
      end
      SEG_THREE: begin
        span_new  = tot34 - e2;
        accel_sel = accel_three_q;
      end
      default: begin
        span_new  = tot34;
        accel_sel = accel_one_q;
      end
    endcase
    accel_abs = accel_sel[15] ? (-{accel_sel[15], accel_sel}) : {1'b0, accel_sel};
  end

  // base speed of the chosen segment
  logic [15:0] base_speed;
  always_comb begin
    case (seg_q)
      SEG_TWO:   base_speed = speed_one_q;
      SEG_THREE: base_speed = speed_two_q;
      default:   base_speed = vs_q;
    endcase
  end

  // radicand v^2 +/- 2*|a|*d
  logic [50:0]        twice_ad;
  logic signed [50:0] rad;
  logic               rad_pos;
  always_comb begin
    twice_ad = {2'b00, mul_p[47:0], 1'b0};
    rad      = {19'd0, vsq_q} + (aneg_q ? (-twice_ad) : twice_ad);
    rad_pos  = !rad[50] && (rad != '0);
  end

  // final speed selection and clamps
  logic [24:0] raw_speed;
  logic [24:0] lo_clamped;
  logic [15:0] speed_final;
  always_comb begin
    case (seg_q)
      SEG_HOLD:  raw_speed = {9'd0, vs_q};
      SEG_ONE:   raw_speed = rneg_q ? {9'd0, lo_q} : root_q;
      SEG_TWO:   raw_speed = root_q;
      SEG_THREE: raw_speed = root_q;
      default:   raw_speed = first_q ? {9'd0, vs_q} : {9'd0, prev_speed_q};
    endcase
    lo_clamped  = (raw_speed < {9'd0, lo_q}) ? {9'd0, lo_q} : raw_speed;
    speed_final = (lo_clamped > {9'd0, hi_q}) ? hi_q : lo_clamped[15:0];
  end

  logic out_free;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer: next state and unit requests
  always_comb begin
    state_d        = state_q;
    mul_req        = '0;
    root_req.start = 1'b0;
    root_req.rad   = sq_sum[63:0];
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = s_axis_tuser ? ST_TOTAL : ST_SQX;
        end
      end
      ST_SQX: begin
        mul_req = '{en: 1'b1, a: ax, b: ax};
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_req = '{en: 1'b1, a: ay, b: ay};
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sq_sum[64]) begin
          state_d = ST_TOTAL;
        end else begin
          root_req.start = 1'b1;
          state_d        = ST_ROOT1;
        end
      end
      ST_ROOT1: begin
        if (root_sts.done) begin
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (seg_new == SEG_HOLD || seg_new == SEG_PAST) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MULV;
        end
      end
      ST_MULV: begin
        mul_req = '{en: 1'b1, a: {16'd0, base_speed}, b: {16'd0, base_speed}};
        state_d = ST_MULA;
      end
      ST_MULA: begin
        mul_req = '{en: 1'b1, a: {16'd0, amag_q}, b: span_q};
        state_d = ST_RAD;
      end
      ST_RAD: begin
        root_req.rad = {13'd0, rad};
        if (rad_pos) begin
          root_req.start = 1'b1;
          state_d        = ST_ROOT2;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_ROOT2: begin
        if (root_sts.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // trajectory state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      dist_q       <= '0;
      prev_speed_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (state_q == ST_FINISH && out_free) begin
        prev_x_q     <= px_q;
        prev_y_q     <= py_q;
        dist_q       <= total_q;
        prev_speed_q <= speed_final;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          px_q    <= s_axis_tdata[31:0];
          py_q    <= s_axis_tdata[63:32];
          vs_q    <= s_axis_tdata[79:64];
          off_q   <= s_axis_tdata[111:80];
          lo_q    <= s_axis_tdata[127:112];
          hi_q    <= s_axis_tdata[143:128];
          first_q <= s_axis_tuser;
        end
      end
      ST_SQY: begin
        sx_q <= mul_p;
      end
      ST_SUM: begin
        step_q <= 33'h1_0000_0000;
      end
      ST_ROOT1: begin
        step_q <= {1'b0, root_sts.root};
      end
      ST_TOTAL: begin
        total_q <= total_new;
      end
      ST_DECIDE: begin
        seg_q  <= seg_new;
        span_q <= span_new[31:0];
        amag_q <= accel_abs[15:0];
        aneg_q <= accel_sel[15];
      end
      ST_MULA: begin
        vsq_q <= mul_p[31:0];
      end
      ST_RAD: begin
        root_q <= '0;
        rneg_q <= rad[50];
      end
      ST_ROOT2: begin
        root_q <= root_sts.root[24:0];
      end
      ST_FINISH: begin
        if (out_free) begin
          out_speed_q <= speed_final;
          out_dist_q  <= total_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_dist_q, out_speed_q};

  // checks
  `PK_ASSERT(a_root_start_idle, clk_i, rst_ni, root_req.start |-> !root_sts.busy,
             "root unit started while busy")
  `PK_ASSERT(a_root_done_state, clk_i, rst_ni,
             root_sts.done |-> (state_q == ST_ROOT1 || state_q == ST_ROOT2),
             "root result outside a root state")
  `PK_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
             (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE),
             "sequencer did not start after an input transaction")
  `PK_ASSERT(a_result_from_finish, clk_i, rst_ni,
             $rose(m_valid_q) |-> $past(state_q == ST_FINISH),
             "result raised outside the finish step")
  `PK_ASSERT_NR(a_ready_root_idle, clk_i, !(s_axis_tready && root_sts.busy),
                "ready while the root unit is busy")

endmodule

`default_nettype wire

### design/pkspd_mul.sv
// ----------------------------------------------------------------------------
// pkspd_mul
// Shared 32 x 32 unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module pkspd_mul
  import pkspd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire pkspd_mul_req_t req_i,
  output logic [63:0]         prod_o
);

  logic [63:0] prod_q;

  // product register, loaded on request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### design/pkspd_isqrt.sv
// ----------------------------------------------------------------------------
// pkspd_isqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pkspd_isqrt
  import pkspd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pkspd_root_req_t req_i,
  output pkspd_root_sts_t      sts_o
);

  logic [63:0]         val_q;
  logic [31:0]         rem_q;
  logic [31:0]         root_q;
  logic [ROOT_CW-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [33:0] rem_shift;
  logic [33:0] trial;
  logic [33:0] rem_sub;
  logic        take;

  // one restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_shift = {rem_q, val_q[63:62]};
    trial     = {root_q, 2'b01};
    take      = rem_shift >= trial;
    rem_sub   = take ? (rem_shift - trial) : rem_shift;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_q <= !req_i.start && busy_q && (cnt_q == ROOT_CW'(ROOT_STEPS - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ROOT_CW'(ROOT_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      val_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= rem_sub[31:0];
      root_q <= {root_q[30:0], take};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.root = root_q;

endmodule

`default_nettype wire

### verif/speed_profile_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speed_profile_checker
// Watches the register port and both streams of the speed profile block,
// keeps its own copy of the registers and of the trajectory state, works out
// target speed and planned distance for every accepted point and compares
// them with the results in order of arrival
// ----------------------------------------------------------------------------

module speed_profile_checker
  import pkspd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // point_x, point_y, start_speed, start_offset, lower_bound, upper_bound
  input  logic [143:0] s_axis_tdata,
  // first_point
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // target_speed, planned_distance
  input  logic [47:0]  m_axis_tdata,
  output int           mismatch_count_o,
  output int           pending_count_o
);

  localparam longint DIST_SLACK = 1;
  localparam longint DIST_CEIL  = 64'sd2147483647;
  localparam longint STEP_CEIL  = 64'sh1_0000_0000;

  // planned_distance above target_speed, as on the result bus
  typedef struct packed {
    logic [31:0] distance;
    logic [15:0] speed;
  } profile_t;

  profile_t expected_profiles_q[$];

  // register copy
  longint accel_seg1, accel_seg2, accel_seg3;
  longint end_seg1, end_seg2, end_seg3;
  longint speed_seg1, speed_seg2;

  // trajectory state
  longint last_x, last_y, distance_acc, last_speed;
  int     mismatches;

  // bit-serial integer square root, floor
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, b;
    rem  = v;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // root of a radicand that is taken as zero when not positive
  function automatic longint clipped_root(input longint rad);
    if (rad <= 0) return 0;
    return longint'(int_sqrt(rad));
  endfunction

  // one point: update distance and state, pick and clamp the speed
  task automatic advance_profile(
    input  logic signed [31:0] px_w,
    input  logic signed [31:0] py_w,
    input  logic               first_w,
    input  logic        [15:0] vs_w,
    input  logic signed [31:0] offset_w,
    input  logic        [15:0] lo_w,
    input  logic        [15:0] hi_w,
    output profile_t           res
  );
    longint      px, py, vs, offset, lo, hi, dx, dy, tot, spd, rad;
    logic [63:0] ax, ay, step_len;
    logic [64:0] sq;
    px     = px_w;
    py     = py_w;
    vs     = vs_w;
    offset = offset_w;
    lo     = lo_w;
    hi     = hi_w;

    if (first_w) begin
      tot        = (offset > 0) ? 0 : offset;
      last_speed = vs;
    end else begin
      dx = px - last_x;
      dy = py - last_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // sum of squares may carry out of 64 bits: step then sits at its ceiling
      sq = {1'b0, ax * ax} + {1'b0, ay * ay};
      if (ax >= STEP_CEIL || ay >= STEP_CEIL || sq[64]) begin
        step_len = STEP_CEIL;
      end else begin
        step_len = int_sqrt(sq[63:0]);
      end
      tot = distance_acc + longint'(step_len);
      if (tot > DIST_CEIL) tot = DIST_CEIL;
    end

    // segment choice by distance
    if (tot <= DIST_SLACK) begin
      spd = vs;
    end else if (tot <= end_seg1 + DIST_SLACK) begin
      rad = vs * vs + 2 * accel_seg1 * tot;
      spd = (rad < 0) ? lo : clipped_root(rad);
    end else if (tot > end_seg1 && tot <= end_seg2 + DIST_SLACK) begin
      spd = clipped_root(speed_seg1 * speed_seg1 + 2 * accel_seg2 * (tot - end_seg1));
    end else if (tot > end_seg2 && tot <= end_seg3 + DIST_SLACK) begin
      spd = clipped_root(speed_seg2 * speed_seg2 + 2 * accel_seg3 * (tot - end_seg2));
    end else begin
      spd = last_speed;
    end

    // lower bound first, upper bound wins
    if (spd < lo) spd = lo;
    if (spd > hi) spd = hi;

    last_x       = px;
    last_y       = py;
    distance_acc = tot;
    last_speed   = spd;

    res.speed    = spd[15:0];
    res.distance = tot[31:0];
  endtask

  // register writes, result checks and predictions
  always @(posedge clk_i) begin : monitor
    profile_t got, want, fresh;
    if (!rst_ni) begin
      accel_seg1   = 0;
      accel_seg2   = 0;
      accel_seg3   = 0;
      end_seg1     = 0;
      end_seg2     = 0;
      end_seg3     = 0;
      speed_seg1   = 0;
      speed_seg2   = 0;
      last_x       = 0;
      last_y       = 0;
      distance_acc = 0;
      last_speed   = 0;
      mismatches   = 0;
      expected_profiles_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_ONE:   accel_seg1 = $signed(cfg_data_i[15:0]);
          CFG_ACCEL_TWO:   accel_seg2 = $signed(cfg_data_i[15:0]);
          CFG_ACCEL_THREE: accel_seg3 = $signed(cfg_data_i[15:0]);
          CFG_END_ONE:     end_seg1   = $signed(cfg_data_i);
          CFG_END_TWO:     end_seg2   = $signed(cfg_data_i);
          CFG_END_THREE:   end_seg3   = $signed(cfg_data_i);
          CFG_SPEED_ONE:   speed_seg1 = cfg_data_i[15:0];
          CFG_SPEED_TWO:   speed_seg2 = cfg_data_i[15:0];
          default: ;
        endcase
      end

      // a result always belongs to an earlier point, so check before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_profiles_q.size() == 0) begin
          $error("result transaction with nothing expected: target_speed %0d, %s %0d",
                 got.speed, "planned_distance", $signed(got.distance));
          mismatches++;
        end else begin
          want = expected_profiles_q.pop_front();
          if (got.speed !== want.speed) begin
            $error("target_speed: expected %0d, actual %0d", want.speed, got.speed);
            mismatches++;
          end
          if (got.distance !== want.distance) begin
            $error("planned_distance: expected %0d, actual %0d",
                   $signed(want.distance), $signed(got.distance));
            mismatches++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        advance_profile(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser,
                        s_axis_tdata[79:64], s_axis_tdata[111:80],
                        s_axis_tdata[127:112], s_axis_tdata[143:128], fresh);
        expected_profiles_q.insert(expected_profiles_q.size(), fresh);
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= expected_profiles_q.size();
  end

endmodule

### verif/tb_piecewise_kinematic_speed_profile.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_kinematic_speed_profile
// Drives path points through the speed profile block under several register
// settings and flow control patterns: a short directed run over the segment
// boundaries and corner cases, then random trajectories with some noise.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_piecewise_kinematic_speed_profile;
  import pkspd_pkg::*;

  localparam int LONG_HOLD   = 500;
  localparam int DRAIN_WAIT  = 80;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               first;
    logic        [15:0] vs;
    logic signed [31:0] offset;
    logic        [15:0] lo;
    logic        [15:0] hi;
  } path_point_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // point_x, point_y, start_speed, start_offset, lower_bound, upper_bound
  logic [143:0] s_axis_tdata;
  // first_point
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // target_speed, planned_distance
  logic [47:0]  m_axis_tdata;

  int   mismatch_count;
  int   pending_count;
  int   send_idle_pct;
  int   stall_pct;
  logic hold_req;
  int   stall_left;
  logic hold_served;

  piecewise_kinematic_speed_profile DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  speed_profile_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("[piecewise_kinematic_speed_profile] ERROR");
    $finish;
  end

  // result side: random stall stretches plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_served   <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (hold_req && !hold_served) begin
      m_axis_tready <= 1'b0;
      stall_left    <= LONG_HOLD;
      hold_served   <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic path_point_t make_point(
    input logic signed [31:0] x,
    input logic signed [31:0] y,
    input logic               first,
    input logic        [15:0] vs,
    input logic signed [31:0] offset,
    input logic        [15:0] lo,
    input logic        [15:0] hi
  );
    path_point_t p;
    p.x      = x;
    p.y      = y;
    p.first  = first;
    p.vs     = vs;
    p.offset = offset;
    p.lo     = lo;
    p.hi     = hi;
    return p;
  endfunction

  // offer one point, with an optional gap first, and wait for the transaction
  task automatic push_point(input path_point_t p);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.hi, p.lo, p.offset, p.vs, p.y, p.x};
    s_axis_tuser  <= p.first;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_profile(
    input logic signed [15:0] a1,
    input logic signed [15:0] a2,
    input logic signed [15:0] a3,
    input logic signed [31:0] e1,
    input logic signed [31:0] e2,
    input logic signed [31:0] e3,
    input logic        [15:0] v1,
    input logic        [15:0] v2
  );
    write_reg(CFG_ACCEL_ONE,   32'(a1));
    write_reg(CFG_ACCEL_TWO,   32'(a2));
    write_reg(CFG_ACCEL_THREE, 32'(a3));
    write_reg(CFG_END_ONE,     e1);
    write_reg(CFG_END_TWO,     e2);
    write_reg(CFG_END_THREE,   e3);
    write_reg(CFG_SPEED_ONE,   32'(v1));
    write_reg(CFG_SPEED_TWO,   32'(v2));
    cfg_we_i <= 1'b0;
  endtask

  // mostly whole trajectories with small steps, some noise and headless runs
  task automatic run_random(input int count);
    path_point_t p;
    int          sent, len, k, step_max;
    logic signed [31:0] cx, cy;
    logic        keep_first;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        len      = $urandom_range(4, 50);
        step_max = $urandom_range(50, 3000);
        p.vs = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        p.lo = 16'($urandom_range(0, 2000));
        p.hi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 12000));
        case ($urandom_range(3))
          0:       p.offset = 0;
          1:       p.offset = -$signed({1'b0, 31'($urandom_range(0, 8000))});
          2:       p.offset = -$signed({1'b0, 31'($urandom_range(0, 60000))});
          default: p.offset = {1'b1, 31'($urandom)};
        endcase
        cx = $signed($urandom) >>> 2;
        cy = $signed($urandom) >>> 2;
        keep_first = ($urandom_range(19) != 0);
        for (k = 0; k < len && sent < count; k++) begin
          p.first = (k == 0) && keep_first;
          p.x     = cx;
          p.y     = cy;
          if ($urandom_range(29) == 0) begin
            p.lo = 16'($urandom);
            p.hi = 16'($urandom);
          end
          push_point(p);
          sent++;
          cx = cx + $urandom_range(0, 2 * step_max) - step_max;
          cy = cy + $urandom_range(0, 2 * step_max) - step_max;
        end
      end else begin
        p.x      = $urandom;
        p.y      = $urandom;
        p.first  = $urandom_range(1);
        p.vs     = 16'($urandom);
        p.offset = ($urandom_range(3) == 0) ? 32'($urandom) : {1'b1, 31'($urandom)};
        p.lo     = 16'($urandom);
        p.hi     = 16'($urandom);
        push_point(p);
        sent++;
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int phase;
    int b1, b2, b3;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_ACCEL_ONE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    hold_req      <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // points before any trajectory start run on from the cleared state
    push_point(make_point(100, 0, 1'b0, 0, 0, 0, 16'hffff));
    push_point(make_point(-300, 400, 1'b0, 300, 0, 10, 16'hffff));
    settle();

    // braking profile; segment two radicand can go negative
    load_profile(-200, -300, 150, 15000, 35000, 55000, 1000, 4000);
    push_point(make_point(0, 0, 1'b1, 2000, 0, 0, 16'hffff));
    // positive start offset counts as zero
    push_point(make_point(0, 0, 1'b1, 2000, 5000, 0, 16'hffff));
    // buffer before the start, then through segment one
    push_point(make_point(0, 0, 1'b1, 2500, -3000, 0, 16'hffff));
    push_point(make_point(1000, 0, 1'b0, 2500, -3000, 0, 16'hffff));
    push_point(make_point(4000, 0, 1'b0, 2500, -3000, 0, 16'hffff));
    push_point(make_point(16000, 0, 1'b0, 2500, -3000, 0, 16'hffff));
    // segment one radicand below zero gives the lower bound
    push_point(make_point(0, 0, 1'b1, 1500, 0, 700, 3000));
    push_point(make_point(12000, 0, 1'b0, 1500, 0, 700, 3000));
    push_point(make_point(17000, 0, 1'b0, 1500, 0, 700, 3000));
    push_point(make_point(45000, 0, 1'b0, 1500, 0, 700, 3000));
    push_point(make_point(65000, 0, 1'b0, 1500, 0, 700, 3000));
    // lower bound above upper bound
    push_point(make_point(66000, 0, 1'b0, 1500, 0, 9000, 1000));
    // corner to corner step saturates the distance
    push_point(make_point(32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'hffff,
                          32'sh8000_0000, 0, 16'hffff));
    push_point(make_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 16'hffff,
                          32'sh8000_0000, 0, 16'hffff));
    push_point(make_point(0, 0, 1'b0, 16'hffff, 0, 16'hffff, 16'hffff));
    push_point(make_point(5, -7, 1'b0, 16'hffff, 0, 0, 0));
    push_point(make_point(-1, 32'sh7fff_ffff, 1'b1, 16'hffff, 0, 0, 16'hffff));
    settle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          load_profile(-200, -300, 150, 15000, 35000, 55000, 1000, 4000);
        end
        1: begin
          send_idle_pct = 64;
          stall_pct     = 0;
          load_profile(-32768, 32767, -32768, 4000, 20000, 32'sh7fff_ffff, 16'hffff, 0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 64;
          load_profile(32767, -32768, 32767, 32'sh8000_0000, 0, 30000, 0, 16'hffff);
        end
        4: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          load_profile(16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom_range(0, 60000) - 10000, $urandom_range(0, 60000) - 10000,
                       $urandom_range(0, 60000) - 10000, 16'($urandom), 16'($urandom));
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
          b1 = $urandom_range(0, 20000);
          b2 = b1 + $urandom_range(0, 30000);
          b3 = b2 + $urandom_range(0, 30000);
          load_profile(16'($urandom), 16'($urandom), 16'($urandom), b1, b2, b3,
                       16'($urandom), 16'($urandom));
        end
      endcase
      if (phase == 0) begin
        // long hold-off on the result side while points keep coming
        run_random(20);
        hold_req <= 1'b1;
        run_random(PHASE_ITEMS - 20);
      end else begin
        run_random(PHASE_ITEMS);
      end
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[piecewise_kinematic_speed_profile] OK");
    end else begin
      $display("[piecewise_kinematic_speed_profile] ERROR");
    end
    $finish;
  end

endmodule
